// ----- rtl/bf9_pkg.sv -----
// ----------------------------------------------------------------------------
// bf9_pkg
// Types and fixed constants shared by the 9x9 RGB box filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bf9_pkg;

  localparam int KERNEL_SIZE = 9;
  localparam int RAD         = KERNEL_SIZE / 2;
  localparam int KEEP        = KERNEL_SIZE - 1;
  localparam int AREA        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int BURST       = RAD + 1;

  // floor(s / 81) == (s * RECIP_MUL) >> RECIP_SHIFT for every window sum.
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_MUL   = (2 ** RECIP_SHIFT + AREA - 1) / AREA;
  localparam int RECIP_W     = 15;

  localparam int CSUM_W = 12;
  localparam int WSUM_W = 15;
  localparam int PROD_W = WSUM_W + RECIP_W;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [10:0] WIDTH_RST  = 11'd512;
  localparam logic [12:0] HEIGHT_RST = 13'd512;

  typedef struct packed {
    logic       mode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        last_of_run;
    logic        frame_done;
  } out_word_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [CSUM_W-1:0] r;
    logic [CSUM_W-1:0] g;
    logic [CSUM_W-1:0] b;
  } csum_t;

  typedef struct packed {
    logic [WSUM_W-1:0] r;
    logic [WSUM_W-1:0] g;
    logic [WSUM_W-1:0] b;
  } wsum_t;

  typedef struct packed {
    logic [PROD_W-1:0] r;
    logic [PROD_W-1:0] g;
    logic [PROD_W-1:0] b;
  } prod_t;

  // One column step as it travels down the pipeline.
  typedef struct packed {
    logic        valid;
    logic        mem;
    logic        wr;
    logic        clr;
    logic        emit;
    logic        last;
    logic        done;
    logic [3:0]  nvalid;
    logic [11:0] orow;
    logic [9:0]  ocol;
  } step_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/bf9_cell.sv -----
// ----------------------------------------------------------------------------
// bf9_cell
// One line buffer cell: holds one earlier row, hands its row to the next cell
// and adds its sample into the passing column sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bf9_cell
  import bf9_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire rgb_t          wr_data,
  input  wire logic          use_en,
  input  wire csum_t         sum_in,
  output rgb_t               rd_data,
  output csum_t              sum_out
);

  rgb_t mem [DEPTH];
  rgb_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

  always_comb begin
    sum_out.r = sum_in.r + (use_en ? CSUM_W'(rd_data_r.r) : CSUM_W'(0));
    sum_out.g = sum_in.g + (use_en ? CSUM_W'(rd_data_r.g) : CSUM_W'(0));
    sum_out.b = sum_in.b + (use_en ? CSUM_W'(rd_data_r.b) : CSUM_W'(0));
  end

endmodule

`default_nettype wire

// ----- rtl/bf9_fifo.sv -----
// ----------------------------------------------------------------------------
// bf9_fifo
// Small output queue for finished result words.
// ----------------------------------------------------------------------------
`default_nettype none

module bf9_fifo
  import bf9_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire out_word_t             push_data,
  input  wire logic                  pop,
  output logic                       not_empty,
  output out_word_t                  head,
  output logic [FIFO_CNT_W-1:0]      count
);

  out_word_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                    do_pop;

  assign do_pop     = pop & (cnt_r != '0);
  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
  assign cnt_nxt    = cnt_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = mem[rd_ptr_r];
  assign count     = cnt_r;

endmodule

`default_nettype wire

// ----- rtl/bf9_seq.sv -----
// ----------------------------------------------------------------------------
// bf9_seq
// Input sequencer: tracks frame position and turns each input word into
// one or more column steps for the line buffer chain.
// ----------------------------------------------------------------------------
`default_nettype none

module bf9_seq
  import bf9_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [12:0]   cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire in_word_t      in_data,
  input  wire logic          room,
  output logic [CW-1:0]      rd_addr,
  output step_ctl_t          step_ctl,
  output logic [CW-1:0]      step_col,
  output rgb_t               step_px
);

  localparam int WB = CW + 1;
  localparam int HB = RW + 1;

  logic [10:0]   width_r, width_nxt;
  logic [12:0]   height_r, height_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] drain_row_r, drain_row_nxt;
  logic [CW-1:0] drain_col_r, drain_col_nxt;
  logic          draining_r, draining_nxt;
  logic [2:0]    b_cnt_r, b_cnt_nxt;

  logic          b_mem_r, b_mem_nxt;
  logic          b_emit_all_r, b_emit_all_nxt;
  logic [CW-1:0] b_col_r, b_col_nxt;
  logic [11:0]   b_orow_r, b_orow_nxt;
  logic [9:0]    b_ocol_r, b_ocol_nxt;
  logic [3:0]    b_nv_r, b_nv_nxt;

  step_ctl_t     ctl_r, ctl_nxt;
  logic [CW-1:0] col_r, col_nxt;
  rgb_t          px_r;

  logic [WB-1:0] eff_w;
  logic [HB-1:0] eff_h;
  logic          accept, is_pix, is_drn;
  logic          pix_row_end, pix_frame_end, pix_r_ok, pix_c_ok;
  logic [3:0]    pix_nv;
  logic          d_row_end, d_done, d_first, d_far_in;
  logic [HB-1:0] d_left;
  logic [3:0]    d_nv;
  logic [WB-1:0] d_far;
  logic [RW-1:0] d_start_row;

  always_comb begin
    if (width_r < 11'(RAD + 1)) begin
      eff_w = WB'(RAD + 1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = WB'(MAX_WIDTH);
    end else begin
      eff_w = WB'(width_r);
    end
    if (height_r == '0) begin
      eff_h = HB'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_h = HB'(MAX_HEIGHT);
    end else begin
      eff_h = HB'(height_r);
    end
  end

  assign in_ready = (b_cnt_r == '0) & room;
  assign accept   = in_valid & in_ready;
  assign is_pix   = accept & ~in_data.mode & ~draining_r;
  assign is_drn   = accept & in_data.mode & draining_r;

  assign pix_row_end   = (WB'(in_col_r) + WB'(1)) >= eff_w;
  assign pix_frame_end = pix_row_end & ((HB'(in_row_r) + HB'(1)) >= eff_h);
  assign pix_r_ok      = in_row_r >= RW'(RAD);
  assign pix_c_ok      = in_col_r >= CW'(RAD);
  assign pix_nv        = (in_row_r >= RW'(KEEP)) ? 4'(KEEP) : 4'(in_row_r);

  assign d_row_end   = (WB'(drain_col_r) + WB'(1)) >= eff_w;
  assign d_done      = d_row_end & ((HB'(drain_row_r) + HB'(1)) >= eff_h);
  assign d_first     = (drain_col_r == '0);
  assign d_far       = WB'(drain_col_r) + WB'(RAD);
  assign d_far_in    = d_far < eff_w;
  assign d_left      = eff_h - HB'(drain_row_r);
  assign d_nv        = (eff_h < (d_left + HB'(RAD))) ? 4'(eff_h) : 4'(d_left + HB'(RAD));
  assign d_start_row = (eff_h > HB'(RAD)) ? RW'(eff_h - HB'(RAD)) : '0;

  // Step issue: a pending burst wins, otherwise the accepted word.
  always_comb begin
    ctl_nxt = '0;
    col_nxt = '0;
    if (b_cnt_r != '0) begin
      ctl_nxt.valid  = 1'b1;
      ctl_nxt.mem    = b_mem_r;
      ctl_nxt.emit   = b_emit_all_r | (b_cnt_r == 3'd1);
      ctl_nxt.last   = (b_cnt_r == 3'd1);
      ctl_nxt.nvalid = b_nv_r;
      ctl_nxt.orow   = b_orow_r;
      ctl_nxt.ocol   = b_ocol_r;
      col_nxt        = b_col_r;
    end else if (is_pix) begin
      ctl_nxt.valid  = 1'b1;
      ctl_nxt.mem    = 1'b1;
      ctl_nxt.wr     = 1'b1;
      ctl_nxt.clr    = (in_col_r == '0);
      ctl_nxt.emit   = pix_r_ok & pix_c_ok;
      ctl_nxt.last   = pix_r_ok & pix_c_ok & ~pix_row_end;
      ctl_nxt.nvalid = pix_nv;
      ctl_nxt.orow   = 12'(in_row_r - RAD);
      ctl_nxt.ocol   = 10'(in_col_r - RAD);
      col_nxt        = in_col_r;
    end else if (is_drn) begin
      ctl_nxt.valid  = 1'b1;
      ctl_nxt.mem    = d_first | d_far_in;
      ctl_nxt.clr    = d_first;
      ctl_nxt.emit   = ~d_first;
      ctl_nxt.last   = ~d_first;
      ctl_nxt.done   = d_done;
      ctl_nxt.nvalid = d_nv;
      ctl_nxt.orow   = 12'(drain_row_r);
      ctl_nxt.ocol   = 10'(drain_col_r);
      col_nxt        = d_first ? '0 : CW'(d_far);
    end
  end

  // Burst bookkeeping for row-end trailing steps and the drain row start.
  always_comb begin
    b_cnt_nxt      = b_cnt_r;
    b_mem_nxt      = b_mem_r;
    b_emit_all_nxt = b_emit_all_r;
    b_col_nxt      = b_col_r;
    b_orow_nxt     = b_orow_r;
    b_ocol_nxt     = b_ocol_r;
    b_nv_nxt       = b_nv_r;
    if (b_cnt_r != '0) begin
      b_cnt_nxt  = b_cnt_r - 3'd1;
      b_col_nxt  = b_col_r + CW'(1);
      b_ocol_nxt = b_emit_all_r ? b_ocol_r + 10'd1 : b_ocol_r;
    end else if (is_pix & pix_row_end & pix_r_ok) begin
      b_cnt_nxt      = 3'(RAD);
      b_mem_nxt      = 1'b0;
      b_emit_all_nxt = 1'b1;
      b_col_nxt      = '0;
      b_orow_nxt     = 12'(in_row_r - RAD);
      b_ocol_nxt     = 10'(in_col_r - RAD + 1);
      b_nv_nxt       = '0;
    end else if (is_drn & d_first) begin
      b_cnt_nxt      = 3'(RAD);
      b_mem_nxt      = 1'b1;
      b_emit_all_nxt = 1'b0;
      b_col_nxt      = CW'(1);
      b_orow_nxt     = 12'(drain_row_r);
      b_ocol_nxt     = '0;
      b_nv_nxt       = d_nv;
    end
  end

  // Frame position and configuration.
  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    in_row_nxt    = in_row_r;
    in_col_nxt    = in_col_r;
    drain_row_nxt = drain_row_r;
    drain_col_nxt = drain_col_r;
    draining_nxt  = draining_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  width_nxt  = cfg_data[10:0];
        CFG_IDX_HEIGHT: height_nxt = cfg_data;
        default:        width_nxt  = width_r;
      endcase
      in_row_nxt    = '0;
      in_col_nxt    = '0;
      drain_row_nxt = '0;
      drain_col_nxt = '0;
      draining_nxt  = 1'b0;
    end else if (is_pix) begin
      if (pix_row_end) begin
        in_col_nxt = '0;
        if (pix_frame_end) begin
          in_row_nxt    = '0;
          draining_nxt  = 1'b1;
          drain_row_nxt = d_start_row;
          drain_col_nxt = '0;
        end else begin
          in_row_nxt = in_row_r + RW'(1);
        end
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end else if (is_drn) begin
      if (d_done) begin
        in_row_nxt    = '0;
        in_col_nxt    = '0;
        drain_row_nxt = '0;
        drain_col_nxt = '0;
        draining_nxt  = 1'b0;
      end else if (d_row_end) begin
        drain_col_nxt = '0;
        drain_row_nxt = drain_row_r + RW'(1);
      end else begin
        drain_col_nxt = drain_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      in_row_r    <= '0;
      in_col_r    <= '0;
      drain_row_r <= '0;
      drain_col_r <= '0;
      draining_r  <= 1'b0;
      b_cnt_r     <= '0;
      ctl_r       <= '0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      drain_row_r <= drain_row_nxt;
      drain_col_r <= drain_col_nxt;
      draining_r  <= draining_nxt;
      b_cnt_r     <= b_cnt_nxt;
      ctl_r       <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_mem_r      <= b_mem_nxt;
    b_emit_all_r <= b_emit_all_nxt;
    b_col_r      <= b_col_nxt;
    b_orow_r     <= b_orow_nxt;
    b_ocol_r     <= b_ocol_nxt;
    b_nv_r       <= b_nv_nxt;
    col_r        <= col_nxt;
    px_r         <= '{r: in_data.red_in, g: in_data.green_in, b: in_data.blue_in};
  end

  assign rd_addr  = col_nxt;
  assign step_ctl = ctl_r;
  assign step_col = col_r;
  assign step_px  = px_r;

endmodule

`default_nettype wire

// ----- rtl/box_filter_9x9_rgb.sv -----
// ----------------------------------------------------------------------------
// box_filter_9x9_rgb
// Streaming 9x9 box filter on RGB pixels with a chain of line buffer cells.
// ----------------------------------------------------------------------------
// Pipeline: the step that completes a window passes the column sum, window
// and divide registers before its result word enters the output queue.
// Throughput: one word per cycle; the last pixel of a row with outputs holds
// the input while its trailing steps issue, as does the first drain of a row
// during its replay steps, and the input also waits while the result queue lacks room.
// Reset: synchronous, active low; row buffers need no clearing pass.
`default_nettype none

module box_filter_9x9_rgb
  import bf9_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  // The sequencer turns every accepted word into column steps. A pixel word
  // is one step; at the end of a row with outputs it adds four zero steps
  // that flush the window. The first drain word of a row replays columns
  // zero to four from the line buffers before its first result can be formed.
  logic          room;
  logic [CW-1:0] rd_addr;
  step_ctl_t     step_ctl;
  logic [CW-1:0] step_col;
  rgb_t          step_px;

  bf9_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .room      (room),
    .rd_addr   (rd_addr),
    .step_ctl  (step_ctl),
    .step_col  (step_col),
    .step_px   (step_px)
  );

  // Line buffer chain. Cell i holds the row i+1 above the current one. Each
  // pixel step reads all cells at its column and then writes cell 0 with the
  // new pixel and every other cell with the row its upper neighbor just gave
  // out, so rows move down one cell per image row. Along the way each cell adds
  // its sample into the column sum; cells holding rows above the frame top, or
  // below its bottom while draining, are masked by the step's valid row count.
  rgb_t  cell_rdata [KEEP];
  rgb_t  cell_wdata [KEEP];
  csum_t sum_chain  [KEEP+1];

  assign sum_chain[0] = step_ctl.wr ?
    '{r: CSUM_W'(step_px.r), g: CSUM_W'(step_px.g), b: CSUM_W'(step_px.b)} : '0;
  assign cell_wdata[0] = step_px;

  for (genvar i = 0; i < KEEP; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign cell_wdata[i] = cell_rdata[i-1];
    end
    bf9_cell #(
      .DEPTH (MAX_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rd_addr (rd_addr),
      .wr_en   (step_ctl.valid & step_ctl.wr),
      .wr_addr (step_col),
      .wr_data (cell_wdata[i]),
      .use_en  (step_ctl.mem & (4'(i) < step_ctl.nvalid)),
      .sum_in  (sum_chain[i]),
      .rd_data (cell_rdata[i]),
      .sum_out (sum_chain[i+1])
    );
  end

  // Column sum stage.
  step_ctl_t ctl_b_r, ctl_c_r, ctl_d_r;
  csum_t     csum_b_r;

  // Window stage: the nine most recent column sums and their running total.
  // A step at column zero starts a fresh window holding only its own column.
  csum_t win_col_r   [KERNEL_SIZE];
  csum_t win_col_nxt [KERNEL_SIZE];
  wsum_t wsum_r, wsum_nxt;

  always_comb begin
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      win_col_nxt[k] = win_col_r[k];
    end
    wsum_nxt = wsum_r;
    if (ctl_b_r.valid) begin
      if (ctl_b_r.clr) begin
        for (int k = 0; k < KERNEL_SIZE - 1; k++) begin
          win_col_nxt[k] = '0;
        end
        wsum_nxt.r = WSUM_W'(csum_b_r.r);
        wsum_nxt.g = WSUM_W'(csum_b_r.g);
        wsum_nxt.b = WSUM_W'(csum_b_r.b);
      end else begin
        for (int k = 0; k < KERNEL_SIZE - 1; k++) begin
          win_col_nxt[k] = win_col_r[k+1];
        end
        wsum_nxt.r = wsum_r.r - WSUM_W'(win_col_r[0].r) + WSUM_W'(csum_b_r.r);
        wsum_nxt.g = wsum_r.g - WSUM_W'(win_col_r[0].g) + WSUM_W'(csum_b_r.g);
        wsum_nxt.b = wsum_r.b - WSUM_W'(win_col_r[0].b) + WSUM_W'(csum_b_r.b);
      end
      win_col_nxt[KERNEL_SIZE-1] = csum_b_r;
    end
  end

  // Divide stage: the exact floor of sum / 81 is a multiply by a rounded-up
  // reciprocal followed by a shift, exact over the whole window sum range.
  prod_t prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
      ctl_c_r <= '0;
      ctl_d_r <= '0;
    end else begin
      ctl_b_r <= step_ctl;
      ctl_c_r <= ctl_b_r;
      ctl_d_r <= ctl_c_r;
    end
  end

  always_ff @(posedge clk) begin
    csum_b_r <= sum_chain[KEEP];
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      win_col_r[k] <= win_col_nxt[k];
    end
    wsum_r   <= wsum_nxt;
    prod_r.r <= PROD_W'(wsum_r.r) * PROD_W'(RECIP_MUL);
    prod_r.g <= PROD_W'(wsum_r.g) * PROD_W'(RECIP_MUL);
    prod_r.b <= PROD_W'(wsum_r.b) * PROD_W'(RECIP_MUL);
  end

  // Result words go into a small queue so that row-end bursts and output
  // stalls never hold up the pipeline. The input is taken only when the
  // queue can absorb every result still in flight plus a full burst.
  logic                  fifo_push;
  out_word_t             push_word;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [2:0]            inflight;

  assign fifo_push = ctl_d_r.valid & ctl_d_r.emit;

  always_comb begin
    push_word.red_out     = prod_r.r[RECIP_SHIFT +: 8];
    push_word.green_out   = prod_r.g[RECIP_SHIFT +: 8];
    push_word.blue_out    = prod_r.b[RECIP_SHIFT +: 8];
    push_word.out_row     = ctl_d_r.orow;
    push_word.out_col     = ctl_d_r.ocol;
    push_word.last_of_run = ctl_d_r.last;
    push_word.frame_done  = ctl_d_r.done;
  end

  assign inflight = 3'(step_ctl.valid & step_ctl.emit) + 3'(ctl_b_r.valid & ctl_b_r.emit)
                  + 3'(ctl_c_r.valid & ctl_c_r.emit) + 3'(ctl_d_r.valid & ctl_d_r.emit);
  assign room = (6'(fifo_cnt) + 6'(inflight) + 6'(BURST)) <= 6'(FIFO_DEPTH);

  bf9_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (push_word),
    .pop       (out_ready),
    .not_empty (out_valid),
    .head      (out_data),
    .count     (fifo_cnt)
  );

  // The queue must never be pushed while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> (fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result queue pushed while full");

  // Queued plus in-flight results stay within the queue depth.
  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (6'(fifo_cnt) + 6'(inflight)) <= 6'(FIFO_DEPTH))
    else $error("result budget exceeded");

  // The frame's final result is always an emitted, run-closing word.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_d_r.valid && ctl_d_r.done) |-> (ctl_d_r.emit && ctl_d_r.last))
    else $error("frame end without a closing result");

endmodule

`default_nettype wire
